// File: rtl/core/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest unit.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    // byte source selection for the block store
    typedef enum logic [1:0] {
        t_SRC_DATA = 2'd0,
        t_SRC_PAD  = 2'd1,
        t_SRC_ZERO = 2'd2,
        t_SRC_LEN  = 2'd3
    } t_src;

    // controller -> datapath
    typedef struct packed {
        logic       write_byte;   // store selected byte, count += 8
        t_src       src;
        logic       latch_len;    // save bit count for length field
        logic       round_start;  // load working regs from chain
        logic       round_step;   // one MD5 step
        logic [5:0] round_idx;
        logic       round_done;   // add working regs into chain
        logic       reset_chain;  // back to initial values, count cleared
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [5:0] fill;         // byte position of next write
    } t_status;

    function automatic logic [31:0] round_k(input logic [5:0] k);
        logic [31:0] r;
        case (k)
            6'd0:  r = 32'hd76aa478; 6'd1:  r = 32'he8c7b756;
            6'd2:  r = 32'h242070db; 6'd3:  r = 32'hc1bdceee;
            6'd4:  r = 32'hf57c0faf; 6'd5:  r = 32'h4787c62a;
            6'd6:  r = 32'ha8304613; 6'd7:  r = 32'hfd469501;
            6'd8:  r = 32'h698098d8; 6'd9:  r = 32'h8b44f7af;
            6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193;
            6'd14: r = 32'ha679438e; 6'd15: r = 32'h49b40821;
            6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa;
            6'd20: r = 32'hd62f105d; 6'd21: r = 32'h02441453;
            6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6;
            6'd26: r = 32'hf4d50d87; 6'd27: r = 32'h455a14ed;
            6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a;
            6'd32: r = 32'hfffa3942; 6'd33: r = 32'h8771f681;
            6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9;
            6'd38: r = 32'hf6bb4b60; 6'd39: r = 32'hbebfbc70;
            6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05;
            6'd44: r = 32'hd9d4d039; 6'd45: r = 32'he6db99e5;
            6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97;
            6'd50: r = 32'hab9423a7; 6'd51: r = 32'hfc93a039;
            6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1;
            6'd56: r = 32'h6fa87e4f; 6'd57: r = 32'hfe2ce6e0;
            6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235;
            6'd62: r = 32'h2ad7d2bb; default: r = 32'heb86d391;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] k);
        logic [4:0] r;
        case ({k[5:4], k[1:0]})
            4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] word_idx(input logic [5:0] k);
        logic [3:0] r;
        case (k[5:4])
            2'd0:    r = k[3:0];
            2'd1:    r = 4'(k[3:0] * 4'd5 + 4'd1);
            2'd2:    r = 4'(k[3:0] * 4'd3 + 4'd5);
            default: r = 4'(k[3:0] * 4'd7);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/md5_datapath.sv
// ----------------------------------------------------------------------------
// md5_datapath
// Block store, bit count, chaining words and one MD5 step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  md5_pkg::t_cmd     i_cmd,
    input  wire  [7:0]        i_data_byte,
    input  wire  [1:0]        i_word_sel,
    output md5_pkg::t_status  o_status,
    output logic [31:0]       o_word
);
    import md5_pkg::*;

    logic [31:0] r_block [16];
    logic [63:0] r_count;
    logic [63:0] r_len;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;

    logic [7:0]  byte_sel;
    logic [31:0] f, sum, rot;
    logic [5:0]  pos;
    logic [2:0]  len_idx;

    assign pos     = r_count[8:3];
    assign len_idx = pos[2:0];
    assign o_status.fill = pos;

    always_comb begin
        case (i_cmd.src)
            t_SRC_DATA: byte_sel = i_data_byte;
            t_SRC_PAD:  byte_sel = PAD_BYTE;
            t_SRC_ZERO: byte_sel = 8'h00;
            default:    byte_sel = r_len[{len_idx, 3'b000} +: 8];
        endcase
    end

    always_comb begin
        case (i_cmd.round_idx[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + r_block[word_idx(i_cmd.round_idx)] + round_k(i_cmd.round_idx);
        rot = 32'(({sum, sum} << round_s(i_cmd.round_idx)) >> 32);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte) begin
            r_block[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= byte_sel;
        end
        if (i_cmd.latch_len) begin
            r_len <= r_count;
        end
        if (i_cmd.round_start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.round_step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= rot + r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_chain) begin
            r_count    <= '0;
            r_chain[0] <= INIT_A;
            r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C;
            r_chain[3] <= INIT_D;
        end else begin
            if (i_cmd.write_byte) begin
                r_count <= r_count + 64'd8;
            end
            if (i_cmd.round_done) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
        end
    end

    assign o_word = r_chain[i_word_sel];

endmodule
`default_nettype wire

// File: rtl/core/md5_control.sv
// ----------------------------------------------------------------------------
// md5_control
// Sequencer: byte intake, padding, 64-step compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_control (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_op,
    input  md5_pkg::t_status  i_status,
    output md5_pkg::t_cmd     o_cmd,
    output logic [1:0]        o_word_sel,
    output logic              o_valid,
    input  wire               i_stall,
    output logic              o_is_last
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_START, S_ROUND, S_DONE, S_EMIT
    } t_state;

    t_state     r_state;
    logic       r_finish;
    logic       r_pad_wrap;
    logic [5:0] r_k;
    logic [1:0] r_sel;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_word_sel = r_sel;
    assign o_valid   = (r_state == S_EMIT);
    assign o_is_last = (r_sel == 2'd3);

    always_comb begin
        o_cmd = '0;
        o_cmd.round_idx = r_k;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.write_byte = 1'b1;
                    o_cmd.src        = (i_op == OP_FINISH) ? t_SRC_PAD : t_SRC_DATA;
                    o_cmd.latch_len  = (i_op == OP_FINISH);
                end
            end
            S_PAD: begin
                o_cmd.write_byte = 1'b1;
                o_cmd.src = (i_status.fill >= LEN_START && !r_pad_wrap) ? t_SRC_LEN
                                                                        : t_SRC_ZERO;
            end
            S_START: o_cmd.round_start = 1'b1;
            S_ROUND: o_cmd.round_step  = 1'b1;
            S_DONE:  o_cmd.round_done  = 1'b1;
            S_EMIT:  o_cmd.reset_chain = !i_stall && (r_sel == 2'd3);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_finish   <= 1'b0;
            r_pad_wrap <= 1'b0;
            r_k        <= '0;
            r_sel      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_finish   <= (i_op == OP_FINISH);
                        r_pad_wrap <= (i_op == OP_FINISH) && (i_status.fill >= LEN_START);
                        if (i_status.fill == 6'd63) begin
                            r_state <= S_START;
                        end else if (i_op == OP_FINISH) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (i_status.fill == 6'd63) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_k     <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_k <= r_k + 6'd1;
                    if (r_k == 6'd63) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // pad byte landed in the length field: one more block
                    if (!r_finish) begin
                        r_state <= S_IDLE;
                    end else if (!r_pad_wrap) begin
                        r_state <= S_EMIT;
                        r_sel   <= '0;
                    end else begin
                        r_pad_wrap <= 1'b0;
                        r_state    <= S_PAD;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_sel <= r_sel + 2'd1;
                        if (r_sel == 2'd3) begin
                            r_state  <= S_IDLE;
                            r_finish <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 digest of a byte stream: absorb bytes, finish to emit four words.
// ----------------------------------------------------------------------------
// channel | direction | fields               | handshake
// in      | input     | op, data_byte        | i_valid / o_stall
// out     | output    | digest_word, is_last | o_valid / i_stall
//
// An absorb item is taken while idle; the 64th byte of a block then starts
// the compression, one step per cycle through a single round unit.
// A finish item pads one byte per cycle, runs one or two compressions and
// then offers four digest words, one per cycle while the output is not stalled.
// Reset (synchronous, low) loads the initial chaining words and clears the count.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_message_digest_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_op,
    input  wire  [7:0]  i_data_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_is_last
);
    import md5_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [1:0] word_sel;

    md5_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_word_sel (word_sel),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_last  (o_is_last)
    );

    md5_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .i_word_sel  (word_sel),
        .o_status    (status),
        .o_word      (o_digest_word)
    );

endmodule
`default_nettype wire

// File: rtl/core/md5_checker.sv
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks of the MD5 digest unit.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [31:0] o_digest_word,
    input wire        o_is_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_is_last))
        else $error("output item changed while stalled");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while digest is out");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_is_last |=> !o_valid)
        else $error("output continues past last word");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");
endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (.*);
`default_nettype wire

// File: tb/md5_message_digest_unit_tb.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit_tb
// Byte-stream MD5 check: directed messages and messages of random length and
// content are absorbed one byte per item and closed by a finish item; the four
// digest words are compared with a behavioral MD5 held in the bench. The input
// idles and the output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module md5_message_digest_unit_tb;
    import md5_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest_item;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_op = OP_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic        o_is_last;

    md5_message_digest_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_data_byte(i_data_byte), .o_valid(o_valid),
        .i_stall(i_stall), .o_digest_word(o_digest_word), .o_is_last(o_is_last)
    );

    always #4 i_clk = ~i_clk;

    t_msg_item    pending_bytes[$];
    t_digest_item digest_words_due[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           drain_hold = 1'b0;
    bit           stim_done = 1'b0;
    bit           in_taken = 1'b0;

    // bench-side MD5 state
    logic [31:0] hash_chain[4];
    logic [7:0]  hash_block[64];
    logic [63:0] hash_bits;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic md5_compress();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t;
        int          g;
        for (int k = 0; k < 16; k++)
            w[k] = {hash_block[4*k+3], hash_block[4*k+2], hash_block[4*k+1],
                    hash_block[4*k]};
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        for (int k = 0; k < 64; k++) begin
            case (k / 16)
                0: begin f = (b & c) | (~b & d); g = k; end
                1: begin f = (b & d) | (c & ~d); g = 5 * k + 1; end
                2: begin f = b ^ c ^ d;          g = 3 * k + 5; end
                default: begin f = c ^ (b | ~d); g = 7 * k; end
            endcase
            t = a + f + w[g % 16] + round_k(6'(k));
            t = rotl(t, int'(round_s(6'(k)))) + b;
            a = d; d = c; c = b; b = t;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    endtask

    task automatic md5_take(input logic [7:0] v);
        int pos;
        pos = int'(hash_bits[8:3]);
        hash_block[pos] = v;
        hash_bits += 64'd8;
        if (pos == 63) md5_compress();
    endtask

    task automatic md5_apply(input t_msg_item it);
        logic [63:0] len;
        if (it.op == OP_ABSORB) begin
            md5_take(it.data);
        end else begin
            len = hash_bits;
            md5_take(PAD_BYTE);
            while (hash_bits[8:3] != LEN_START) md5_take(8'h00);
            for (int k = 0; k < 8; k++) md5_take(len[8*k +: 8]);
            for (int k = 0; k < 4; k++)
                digest_words_due.push_back('{word: hash_chain[k], last: (k == 3)});
            hash_chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
            hash_bits = '0;
        end
    endtask

    task automatic queue_message(input int len, input int fill_mode);
        for (int k = 0; k < len; k++) begin
            case (fill_mode)
                1: pending_bytes.push_back('{op: OP_ABSORB, data: 8'h00});
                2: pending_bytes.push_back('{op: OP_ABSORB, data: 8'hff});
                default: pending_bytes.push_back('{op: OP_ABSORB,
                                                    data: 8'($urandom_range(0, 255))});
            endcase
        end
        pending_bytes.push_back('{op: OP_FINISH, data: 8'($urandom_range(0, 255))});
    endtask

    initial begin
        int total;
        hash_chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
        hash_bits = '0;
        // directed: empty, single bytes, padding boundaries, full blocks
        queue_message(0, 0);
        queue_message(1, 1);
        queue_message(1, 2);
        queue_message(3, 0);
        queue_message(55, 0);
        queue_message(56, 2);
        queue_message(63, 0);
        queue_message(64, 1);
        queue_message(65, 0);
        queue_message(128, 0);
        total = pending_bytes.size();
        while (total < 480) begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(56, 130)
                                              : $urandom_range(0, 20);
            if (len > 479 - total) len = 479 - total;
            queue_message(len, 0);
            total += len + 1;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        t_msg_item taken;
        if (i_rst_n) begin
            if (in_taken) begin
                taken = pending_bytes.pop_front();
                md5_apply(taken);
                if (taken.op == OP_FINISH && pending_bytes.size() < 240) drain_hold = 1'b1;
            end
            if (drain_hold && digest_words_due.size() == 0) drain_hold = 1'b0;
            if (i_valid && !in_taken) begin
            end else if (gap_left > 0 || drain_hold || pending_bytes.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_valid <= 1'b0;
                if (pending_bytes.size() == 0) stim_done = 1'b1;
            end else begin
                i_valid <= 1'b1;
                i_op <= pending_bytes[0].op;
                i_data_byte <= pending_bytes[0].data;
                gap_left = gap_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = gap_len();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_digest_item due;
        if (i_rst_n) begin
            in_taken = i_valid && !o_stall;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (digest_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h last %b",
                                 o_digest_word, o_is_last);
                end else begin
                    due = digest_words_due.pop_front();
                    if (o_digest_word !== due.word || o_is_last !== due.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%b got %h/%b", due.word,
                                     due.last, o_digest_word, o_is_last);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done && digest_words_due.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && digest_words_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
